@@ rtl/sha384_pkg.sv @@
// ----------------------------------------------------------------------------
// sha384_pkg
// Constants shared by the SHA-384 core: initial hash values and round keys.
// ----------------------------------------------------------------------------
package sha384_pkg;

    typedef logic [63:0] t_word;

    localparam int unsigned NUM_ROUNDS = 80;
    localparam int unsigned BLK_WORDS  = 16;
    localparam int unsigned DIG_WORDS  = 6;

    localparam t_word PAD_WORD = 64'h8000_0000_0000_0000;

    localparam t_word INIT_HASH [8] = '{
        64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17,
        64'h152fecd8f70e5939, 64'h67332667ffc00b31, 64'h8eb44a8768581511,
        64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4
    };

    localparam t_word ROUND_K [80] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f,
        64'he9b5dba58189dbbc, 64'h3956c25bf348b538, 64'h59f111f1b605d019,
        64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118, 64'hd807aa98a3030242,
        64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235,
        64'hc19bf174cf692694, 64'he49b69c19ef14ad2, 64'hefbe4786384f25e3,
        64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65, 64'h2de92c6f592b0275,
        64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f,
        64'hbf597fc7beef0ee4, 64'hc6e00bf33da88fc2, 64'hd5a79147930aa725,
        64'h06ca6351e003826f, 64'h142929670a0e6e70, 64'h27b70a8546d22ffc,
        64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6,
        64'h92722c851482353b, 64'ha2bfe8a14cf10364, 64'ha81a664bbc423001,
        64'hc24b8b70d0f89791, 64'hc76c51a30654be30, 64'hd192e819d6ef5218,
        64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99,
        64'h34b0bcb5e19b48a8, 64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb,
        64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3, 64'h748f82ee5defb2fc,
        64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915,
        64'hc67178f2e372532b, 64'hca273eceea26619c, 64'hd186b8c721c0c207,
        64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178, 64'h06f067aa72176fba,
        64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc,
        64'h431d67c49c100d4c, 64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a,
        64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

endpackage

@@ rtl/sha384_round.sv @@
// ----------------------------------------------------------------------------
// sha384_round
// One compression round plus one message schedule step, reused 80 times.
// ----------------------------------------------------------------------------
module sha384_round (
    input  sha384_pkg::t_word i_v [8],
    input  sha384_pkg::t_word i_k,
    input  sha384_pkg::t_word i_w,
    input  sha384_pkg::t_word i_w2,
    input  sha384_pkg::t_word i_w7,
    input  sha384_pkg::t_word i_w15,
    input  sha384_pkg::t_word i_w16,
    output sha384_pkg::t_word o_v [8],
    output sha384_pkg::t_word o_wnew
);
    sha384_pkg::t_word big1, big0, choose, major, t1, t2, s0, s1;
    sha384_pkg::t_word a, e;

    assign a      = i_v[0];
    assign e      = i_v[4];
    assign big1   = {e[13:0], e[63:14]} ^ {e[17:0], e[63:18]} ^ {e[40:0], e[63:41]};
    assign big0   = {a[27:0], a[63:28]} ^ {a[33:0], a[63:34]} ^ {a[38:0], a[63:39]};
    assign choose = (e & i_v[5]) ^ (~e & i_v[6]);
    assign major  = (a & i_v[1]) ^ (a & i_v[2]) ^ (i_v[1] & i_v[2]);
    assign t1     = i_v[7] + big1 + choose + i_k + i_w;
    assign t2     = big0 + major;

    assign o_v[0] = t1 + t2;
    assign o_v[1] = i_v[0];
    assign o_v[2] = i_v[1];
    assign o_v[3] = i_v[2];
    assign o_v[4] = i_v[3] + t1;
    assign o_v[5] = i_v[4];
    assign o_v[6] = i_v[5];
    assign o_v[7] = i_v[6];

    assign s1 = {i_w2[18:0], i_w2[63:19]} ^ {i_w2[60:0], i_w2[63:61]} ^ (i_w2 >> 6);
    assign s0 = {i_w15[0], i_w15[63:1]} ^ {i_w15[7:0], i_w15[63:8]} ^ (i_w15 >> 7);
    assign o_wnew = s1 + i_w7 + s0 + i_w16;
endmodule

@@ rtl/sha384_hash_core.sv @@
// ----------------------------------------------------------------------------
// sha384_hash_core
// Streaming SHA-384 engine with hardware padding and six-word digest output.
// ----------------------------------------------------------------------------
// Each accepted word is stored in the block buffer. The word that fills a
// 1024-bit block starts a compression: a load of the working registers,
// 80 rounds at one round a cycle through a single shared round unit, and
// the chaining update. The core is not ready meanwhile. The last word starts
// in-core padding: pad words are written one a cycle, with one or two
// compressions, and then the six digest words are sent through an output
// register, one per accepted beat.
module sha384_hash_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // [63:0] message_word, [67:64] valid_bytes
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [63:0] digest_word, [66:64] digest_index
    output logic        m_axis_tlast
);
    typedef enum logic [2:0] {
        S_IN, S_PAD, S_LOAD, S_RUN, S_ADD, S_OUT
    } t_state;

    t_state            r_state;
    logic [3:0]        r_cnt;
    logic [6:0]        r_rnd;
    logic [63:0]       r_len;
    logic              r_pad;      // padding in progress
    logic              r_lenw;     // length word still to write
    logic              r_mark;     // 0x80 marker word still to write
    logic              r_wrap;     // marker block has no room for the length
    logic [2:0]        r_oidx;
    sha384_pkg::t_word r_h [8];
    sha384_pkg::t_word r_v [8];
    sha384_pkg::t_word r_w [16];   // sliding schedule window
    sha384_pkg::t_word r_od;

    sha384_pkg::t_word nv [8];
    sha384_pkg::t_word wnew;
    logic [3:0]        nb;
    logic [63:0]       keep, lastw, padw;
    logic [63:0]       nlen;
    logic              acc, lastacc;

    sha384_round u_round (
        .i_v   (r_v),
        .i_k   (sha384_pkg::ROUND_K[r_rnd]),
        .i_w   (r_w[0]),
        .i_w2  (r_w[14]),
        .i_w7  (r_w[9]),
        .i_w15 (r_w[1]),
        .i_w16 (r_w[0]),
        .o_v   (nv),
        .o_wnew(wnew)
    );

    assign s_axis_tready = (r_state == S_IN);
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign lastacc       = acc && s_axis_tlast;
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = {5'd0, r_oidx, r_od};
    assign m_axis_tlast  = (r_oidx == 3'd5);

    always_comb begin
        nb = (s_axis_tdata[67:64] > 4'd8) ? 4'd8 : s_axis_tdata[67:64];
        if (!s_axis_tlast) begin
            nb = 4'd8;
        end
        keep  = (nb == 4'd0) ? 64'd0 : ~(64'hffff_ffff_ffff_ffff >> {nb[3:0], 3'b000});
        lastw = (s_axis_tdata[63:0] & keep) |
                ((nb == 4'd8) ? 64'd0 : (64'h80 << (7'd56 - {nb[2:0], 3'b000})));
        nlen  = r_len + {57'd0, nb, 3'b000};
        // pad source: marker, zeros, length in slot 15 of the final block
        if (r_mark) begin
            padw = sha384_pkg::PAD_WORD;
        end else if (r_cnt == 4'd15 && !r_wrap) begin
            padw = r_len;
        end else begin
            padw = 64'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IN;
            r_cnt   <= '0;
            r_rnd   <= '0;
            r_len   <= '0;
            r_pad   <= 1'b0;
            r_lenw  <= 1'b0;
            r_mark  <= 1'b0;
            r_wrap  <= 1'b0;
            r_oidx  <= '0;
            r_h     <= sha384_pkg::INIT_HASH;
        end else begin
            unique case (r_state)
                S_IN: begin
                    if (acc) begin
                        r_w[r_cnt] <= lastacc ? lastw : s_axis_tdata[63:0];
                        r_cnt      <= r_cnt + 4'd1;
                        r_len      <= nlen;
                        if (lastacc) begin
                            r_pad  <= 1'b1;
                            r_lenw <= 1'b1;
                            // full last word: 0x80 marker goes in its own word
                            r_mark <= (nb == 4'd8);
                            r_wrap <= (nb != 4'd8) && (r_cnt >= 4'd14);
                        end
                        if (r_cnt == 4'd15) begin
                            r_state <= S_LOAD;
                        end else if (lastacc) begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    r_w[r_cnt] <= padw;
                    r_cnt      <= r_cnt + 4'd1;
                    if (r_mark) begin
                        r_mark <= 1'b0;
                        r_wrap <= (r_cnt >= 4'd14);
                    end else if (r_cnt == 4'd15 && !r_wrap) begin
                        r_lenw <= 1'b0;
                    end
                    if (r_cnt == 4'd15) begin
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_v   <= r_h;
                    r_rnd <= '0;
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    r_v <= nv;
                    for (int i = 0; i < 15; i++) begin
                        r_w[i] <= r_w[i + 1];
                    end
                    r_w[15] <= wnew;
                    r_rnd   <= r_rnd + 7'd1;
                    if (r_rnd == 7'(sha384_pkg::NUM_ROUNDS - 1)) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    for (int i = 0; i < 8; i++) begin
                        r_h[i] <= r_h[i] + r_v[i];
                    end
                    if (!r_pad) begin
                        r_state <= S_IN;
                    end else if (r_lenw) begin
                        r_wrap  <= 1'b0;
                        r_state <= S_PAD;
                    end else begin
                        r_od    <= r_h[0] + r_v[0];
                        r_oidx  <= '0;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (m_axis_tready) begin
                        r_oidx <= r_oidx + 3'd1;
                        r_od   <= r_h[3'(r_oidx + 3'd1)];
                        if (r_oidx == 3'(sha384_pkg::DIG_WORDS - 1)) begin
                            r_h     <= sha384_pkg::INIT_HASH;
                            r_len   <= '0;
                            r_cnt   <= '0;
                            r_pad   <= 1'b0;
                            r_state <= S_IN;
                        end
                    end
                end
                default: r_state <= S_IN;
            endcase
        end
    end

endmodule
